// ===== hw/rtl/tclru_pkg.sv =====
// Shared types and constants for the tile tag store.
// No dependencies.
`default_nettype none
package tclru_pkg;
  localparam int ENTRIES_DEF = 64;
  localparam int TAG_COL_W = 20;
  localparam int TAG_ROW_W = 20;
  localparam int TAG_ZOOM_W = 5;
  localparam int STAMP_W = 32;
  localparam int SLOT_W = 6;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request fields
    logic scan_init; // reset scan pointer and running best
    logic scan_step; // examine one entry
    logic commit;    // apply update and drive result
  } tclru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic [1:0] op;
  } tclru_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tclru_ctrl.sv =====
// Controller for the tile tag store: sequences capture, entry scan and commit.
// Depends on tclru_pkg.
`default_nettype none
module tclru_ctrl
  import tclru_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output tclru_cmd_t       cmd,
  input  tclru_stat_t      stat
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.scan_init = 1'b1;
        // clear and undefined ops need no scan
        if (stat.op == OP_LOOKUP || stat.op == OP_INSERT) state_next = S_SCAN;
        else state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_commit_from_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.scan_step || cmd.scan_init))
    else $error("commit without scan");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan_init)
    else $error("load not followed by init");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("overlapping commands");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tclru_dp.sv =====
// Datapath for the tile tag store: tag/stamp memories, valid bits, counter,
// one-entry-per-cycle scan for match, free slot and oldest stamp. Uses tclru_pkg.
`default_nettype none
module tclru_dp
  import tclru_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [1:0]            op,
  input  wire logic [TAG_COL_W-1:0]  tile_col,
  input  wire logic [TAG_ROW_W-1:0]  tile_row,
  input  wire logic [TAG_ZOOM_W-1:0] zoom_level,
  input  wire logic                  load_ok,
  input  tclru_cmd_t                 cmd,
  output tclru_stat_t                stat,
  output logic                       done,
  output logic                       hit,
  output logic [SLOT_W-1:0]          slot_index,
  output logic                       evicted
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW = TAG_COL_W + TAG_ROW_W + TAG_ZOOM_W;

  logic [TW-1:0]      tag_mem [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [STAMP_W-1:0] use_counter;

  logic [1:0]            op_q;
  logic [TW-1:0]         key_q;
  logic                  ok_q;
  logic [IW-1:0]         ptr;      // address being read this cycle
  logic [IW-1:0]         rd_idx;   // address of registered read data
  logic                  rd_vld;
  logic [TW-1:0]         tag_rd;
  logic [STAMP_W-1:0]    stamp_rd;

  logic                  found;
  logic [IW-1:0]         found_idx;
  logic                  free_found;
  logic [IW-1:0]         free_idx;
  logic [STAMP_W-1:0]    oldest;
  logic [IW-1:0]         old_idx;

  assign stat.op = op_q;
  // last step is the one that consumes the final registered read
  assign stat.scan_last = rd_vld && (rd_idx == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      key_q <= {tile_col, tile_row, zoom_level};
      ok_q  <= load_ok;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    tag_rd   <= tag_mem[ptr];
    stamp_rd <= stamp_mem[ptr];
    rd_idx   <= ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      ptr <= '0;
    end else if (cmd.scan_init) begin
      ptr <= (ENTRIES > 1) ? IW'(1) : '0;
      rd_vld <= 1'b1;
    end else if (cmd.scan_step) begin
      if (ptr != IW'(ENTRIES - 1)) ptr <= ptr + IW'(1);
      rd_vld <= !stat.scan_last;
    end else begin
      ptr <= '0;
      rd_vld <= 1'b0;
    end
  end

  // running scan results
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      found <= 1'b0;
      found_idx <= '0;
      free_found <= 1'b0;
      free_idx <= '0;
      oldest <= use_counter;
      old_idx <= '0;
    end else if (cmd.scan_step && rd_vld) begin
      if (!found && entry_valid[rd_idx] && tag_rd == key_q) begin
        found <= 1'b1;
        found_idx <= rd_idx;
      end
      if (!free_found && !entry_valid[rd_idx]) begin
        free_found <= 1'b1;
        free_idx <= rd_idx;
      end
      if (stamp_rd < oldest) begin
        oldest <= stamp_rd;
        old_idx <= rd_idx;
      end
    end
  end

  logic [IW-1:0] ins_idx;
  assign ins_idx = free_found ? free_idx : old_idx;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_q == OP_LOOKUP && found) stamp_mem[found_idx] <= use_counter;
      if (op_q == OP_INSERT && ok_q) begin
        stamp_mem[ins_idx] <= use_counter;
        tag_mem[ins_idx] <= key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      use_counter <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_LOOKUP: if (found) use_counter <= use_counter + STAMP_W'(1);
        OP_INSERT: begin
          entry_valid[ins_idx] <= ok_q;
          if (ok_q) use_counter <= use_counter + STAMP_W'(1);
        end
        OP_CLEAR: entry_valid <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= 1'b0;
      slot_index <= '0;
      evicted <= 1'b0;
      if (op_q == OP_LOOKUP && found) begin
        hit <= 1'b1;
        slot_index <= SLOT_W'(found_idx);
      end else if (op_q == OP_INSERT) begin
        slot_index <= SLOT_W'(ins_idx);
        evicted <= !free_found;
      end
    end
  end

`ifndef SYNTHESIS
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_LOOKUP && found) |-> entry_valid[found_idx])
    else $error("hit on invalid entry");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit) && !$past(rst) |-> $stable(use_counter))
    else $error("counter moved outside commit");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_CLEAR) |=> entry_valid == '0)
    else $error("clear left valid entries");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tile_cache_lru_lookup.sv =====
// Top level of the tile tag store: controller plus datapath.
// Depends on tclru_pkg, tclru_ctrl, tclru_dp.
//
//  channel   | handshake       | payload
//  request   | start / busy    | op, tile_col, tile_row, zoom_level, load_ok
//  result    | done (1 cycle)  | hit, slot_index, evicted
//
// Lookup and insert scan one entry per cycle through the
// tag/stamp memory read port. Clear and undefined ops skip the scan.
// Reset clears valid bits and the use counter directly; no clearing pass.
// Results cannot be stalled; done pulses for one cycle as busy drops.
`default_nettype none
module tile_cache_lru_lookup
  import tclru_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            op,
  input  wire logic [TAG_COL_W-1:0]  tile_col,
  input  wire logic [TAG_ROW_W-1:0]  tile_row,
  input  wire logic [TAG_ZOOM_W-1:0] zoom_level,
  input  wire logic                  load_ok,
  output logic                       done,
  output logic                       hit,
  output logic [SLOT_W-1:0]          slot_index,
  output logic                       evicted
);
  tclru_cmd_t  cmd;
  tclru_stat_t stat;

  tclru_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  tclru_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .op(op), .tile_col(tile_col), .tile_row(tile_row),
    .zoom_level(zoom_level), .load_ok(load_ok), .cmd(cmd), .stat(stat),
    .done(done), .hit(hit), .slot_index(slot_index), .evicted(evicted)
  );
endmodule
`default_nettype wire
